@@ rtl/vftp_pkg.sv @@
// Package for the task picker: slot constants, opcodes, state codes and payload words.
// Depends on nothing; every module of the block uses it.
`default_nettype none
package vftp_pkg;
  localparam int Slots = 16;
  localparam int SlotW = 4;

  localparam logic [2:0] OP_TICK = 3'd0;
  localparam logic [2:0] OP_SWITCH = 3'd1;
  localparam logic [2:0] OP_ADD = 3'd2;
  localparam logic [2:0] OP_REMOVE = 3'd3;
  localparam logic [2:0] OP_NICE = 3'd4;
  localparam logic [2:0] OP_STATE = 3'd5;

  localparam logic [1:0] ST_READY = 2'd0;
  localparam logic [1:0] ST_RUNNING = 2'd1;
  localparam logic [1:0] ST_BLOCKED = 2'd2;
  localparam logic [1:0] ST_ENDED = 2'd3;

  localparam logic [0:0] REG_TIMESLICE = 1'd0;
  localparam logic [0:0] REG_POOL = 1'd1;

  typedef struct packed {
    logic [2:0] opcode;
    logic [3:0] slot;
    logic signed [7:0] nice_value;
    logic [1:0] new_state;
  } in_word_t;

  typedef struct packed {
    logic [3:0] current_slot;
    logic switched;
    logic used_fallback;
    logic [31:0] tick_count;
  } out_word_t;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic start;      // latch the item, begin its work
    logic walk;       // examine one ring member
    logic scan;       // examine one pool slot
    logic finish;     // commit the pick / the edit
    logic pred;       // examine one slot as a ring predecessor
  } dp_cmd_t;

  typedef struct packed {
    logic walk_done;
    logic scan_done;
    logic pred_done;
    logic needs_walk;
    logic needs_pred;
  } dp_sts_t;

  // Vruntime increment 10240 / max(1, 1024 - 40 * nice) for nice -20..19, as a table.
  // Stored nice values are always clamped, so other codes never reach it.
  function automatic logic [31:0] vr_inc(input logic signed [5:0] nice);
    logic [31:0] inc;
    case (nice)
      -6'sd20, -6'sd19, -6'sd18: inc = 32'd5;
      -6'sd17, -6'sd16, -6'sd15, -6'sd14, -6'sd13, -6'sd12, -6'sd11: inc = 32'd6;
      -6'sd10, -6'sd9, -6'sd8, -6'sd7: inc = 32'd7;
      -6'sd6, -6'sd5, -6'sd4, -6'sd3: inc = 32'd8;
      -6'sd2, -6'sd1: inc = 32'd9;
      6'sd0, 6'sd1, 6'sd2: inc = 32'd10;
      6'sd3, 6'sd4: inc = 32'd11;
      6'sd5: inc = 32'd12;
      6'sd6, 6'sd7: inc = 32'd13;
      6'sd8: inc = 32'd14;
      6'sd9: inc = 32'd15;
      6'sd10: inc = 32'd16;
      6'sd11: inc = 32'd17;
      6'sd12: inc = 32'd18;
      6'sd13: inc = 32'd20;
      6'sd14: inc = 32'd22;
      6'sd15: inc = 32'd24;
      6'sd16: inc = 32'd26;
      6'sd17: inc = 32'd29;
      6'sd18: inc = 32'd33;
      6'sd19: inc = 32'd38;
      default: inc = 32'd10;
    endcase
    return inc;
  endfunction
endpackage
`default_nettype wire

@@ rtl/vftp_ctrl.sv @@
// Controller state machine of the task picker: sequences ring walk, pool scan and edits.
// Depends on vftp_pkg.
`default_nettype none
module vftp_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_go,
  input  wire vftp_pkg::dp_sts_t sts,
  input  wire logic out_free,
  output vftp_pkg::dp_cmd_t cmd,
  output logic busy
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_DECIDE = 6'b000010, S_WALK = 6'b000100,
    S_SCAN = 6'b001000, S_PRED = 6'b010000, S_DONE = 6'b100000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_go) begin
          cmd.start = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.needs_walk) state_next = S_WALK;
        else if (sts.needs_pred) state_next = S_PRED;
        else state_next = S_DONE;
      end
      S_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) state_next = S_DONE;
      end
      S_PRED: begin
        cmd.pred = 1'b1;
        if (sts.pred_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign busy = (state != S_IDLE);

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> !$past(busy) || $past(cmd.finish)) else $error("start while busy");
  a_fin_done: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> state == S_IDLE) else $error("finish not to idle");
  a_walk_scan: assert property (@(posedge clk) disable iff (rst)
    (cmd.walk && sts.walk_done) |=> state == S_SCAN) else $error("walk exit");
endmodule
`default_nettype wire

@@ rtl/vftp_dp.sv @@
// Datapath of the task picker: task table, ring, tick counter and pick registers.
// Depends on vftp_pkg; driven by vftp_ctrl.
`default_nettype none
module vftp_dp (
  input  wire logic clk,
  input  wire logic rst,
  input  wire vftp_pkg::in_word_t in_word,
  input  wire vftp_pkg::dp_cmd_t cmd,
  input  wire logic [7:0] timeslice,
  input  wire logic [4:0] pool,
  output vftp_pkg::dp_sts_t sts,
  output vftp_pkg::out_word_t res
);
  localparam int SW = vftp_pkg::SlotW;
  localparam int CW = SW + 1;

  logic [1:0] tstate [vftp_pkg::Slots];
  logic [31:0] vrun [vftp_pkg::Slots];
  logic signed [5:0] tnice [vftp_pkg::Slots];
  logic [7:0] slice [vftp_pkg::Slots];
  logic [31:0] cpu [vftp_pkg::Slots];
  logic [SW-1:0] rnext [vftp_pkg::Slots];
  logic [vftp_pkg::Slots-1:0] in_ring;
  logic [SW-1:0] head;
  logic nonempty;
  logic [SW-1:0] running;
  logic [31:0] ticks;

  vftp_pkg::in_word_t item;
  logic [SW-1:0] walk_cur, best, pred;
  logic [CW-1:0] cnt;
  logic fb, pred_found;

  logic [CW-1:0] lim;
  logic best_ready, cur_ready, valid_slot;
  logic signed [5:0] nice_cl;

  assign lim = (pool > CW'(vftp_pkg::Slots)) ? CW'(vftp_pkg::Slots) : pool;
  assign best_ready = tstate[best] == vftp_pkg::ST_READY;
  assign cur_ready = tstate[walk_cur] == vftp_pkg::ST_READY;
  assign valid_slot = 1'b1;

  always_comb begin
    if (item.nice_value < -8'sd20) nice_cl = -6'sd20;
    else if (item.nice_value > 8'sd19) nice_cl = 6'sd19;
    else nice_cl = item.nice_value[5:0];
  end

  assign sts.needs_walk = item.opcode == vftp_pkg::OP_SWITCH && nonempty;
  assign sts.needs_pred = item.opcode == vftp_pkg::OP_REMOVE && valid_slot && nonempty
                          && in_ring[item.slot] && rnext[item.slot] != item.slot;
  assign sts.walk_done = cnt == CW'(vftp_pkg::Slots - 1) || rnext[walk_cur] == head;
  assign sts.scan_done = best_ready || cnt >= lim
                         || tstate[cnt[SW-1:0]] == vftp_pkg::ST_READY;
  assign sts.pred_done = pred_found || cnt == CW'(vftp_pkg::Slots - 1);

  logic [SW-1:0] pick;
  always_comb begin
    if (!nonempty) pick = '0;
    else pick = best;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vftp_pkg::Slots; i++) begin
        tstate[i] <= vftp_pkg::ST_ENDED;
        vrun[i] <= '0;
        tnice[i] <= '0;
        slice[i] <= '0;
        cpu[i] <= '0;
        rnext[i] <= '0;
      end
      tstate[0] <= vftp_pkg::ST_READY;
      in_ring <= '0;
      head <= '0;
      nonempty <= 1'b0;
      running <= '0;
      ticks <= '0;
      res <= '0;
      fb <= 1'b0;
      cnt <= '0;
      pred_found <= 1'b0;
    end else begin
      if (cmd.start) begin
        item <= in_word;
        walk_cur <= head;
        best <= head;
        cnt <= '0;
        fb <= 1'b0;
        pred_found <= 1'b0;
        if (in_word.opcode == vftp_pkg::OP_SWITCH && running != '0
            && slice[running] == '0)
          slice[running] <= timeslice;
      end
      if (cmd.walk) begin
        // The first ready member wins ties; strictly smaller vruntime replaces it.
        if (cur_ready && (!best_ready || vrun[walk_cur] < vrun[best])) best <= walk_cur;
        walk_cur <= rnext[walk_cur];
        cnt <= sts.walk_done ? '0 : cnt + 1'b1;
      end
      if (cmd.scan && !best_ready) begin
        if (cnt < lim && tstate[cnt[SW-1:0]] == vftp_pkg::ST_READY) begin
          best <= cnt[SW-1:0];
          fb <= 1'b1;
        end else if (cnt >= lim) begin
          best <= '0;
        end
        cnt <= cnt + 1'b1;
      end
      if (cmd.pred && !pred_found) begin
        if (in_ring[cnt[SW-1:0]] && rnext[cnt[SW-1:0]] == item.slot) begin
          pred <= cnt[SW-1:0];
          pred_found <= 1'b1;
        end else begin
          cnt <= cnt + 1'b1;
        end
      end
      if (cmd.finish) begin
        res.switched <= 1'b0;
        res.used_fallback <= 1'b0;
        res.current_slot <= running;
        res.tick_count <= ticks;
        case (item.opcode)
          vftp_pkg::OP_TICK: begin
            if (running != '0) begin
              cpu[running] <= cpu[running] + 32'd1;
              vrun[running] <= vrun[running] + vftp_pkg::vr_inc(tnice[running]);
              if (slice[running] != '0) slice[running] <= slice[running] - 8'd1;
            end
            ticks <= ticks + 32'd1;
            res.tick_count <= ticks + 32'd1;
          end
          vftp_pkg::OP_SWITCH: begin
            res.used_fallback <= nonempty && fb;
            if (pick != running) begin
              running <= pick;
              res.current_slot <= pick;
              res.switched <= 1'b1;
              if (tstate[pick] == vftp_pkg::ST_READY) tstate[pick] <= vftp_pkg::ST_RUNNING;
            end
          end
          vftp_pkg::OP_ADD: begin
            tnice[item.slot] <= '0;
            vrun[item.slot] <= ticks;
            slice[item.slot] <= timeslice;
            tstate[item.slot] <= vftp_pkg::ST_READY;
            if (!in_ring[item.slot]) begin
              in_ring[item.slot] <= 1'b1;
              if (!nonempty) begin
                head <= item.slot;
                rnext[item.slot] <= item.slot;
                nonempty <= 1'b1;
              end else begin
                rnext[item.slot] <= rnext[head];
                rnext[head] <= item.slot;
              end
            end
          end
          vftp_pkg::OP_REMOVE: begin
            if (nonempty && in_ring[item.slot]) begin
              if (rnext[item.slot] == item.slot) begin
                nonempty <= 1'b0;
                head <= '0;
              end else begin
                if (pred_found) rnext[pred] <= rnext[item.slot];
                if (head == item.slot) head <= rnext[item.slot];
              end
              // A self-predecessor cannot occur here, so this write is not overridden.
              if (!(pred_found && pred == item.slot)) rnext[item.slot] <= '0;
              in_ring[item.slot] <= 1'b0;
            end
          end
          vftp_pkg::OP_NICE: tnice[item.slot] <= nice_cl;
          vftp_pkg::OP_STATE: tstate[item.slot] <= item.new_state;
          default: ;
        endcase
      end
    end
  end

  a_fb_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(fb) |-> $past(cmd.scan)) else $error("fallback flag outside scan");
  a_ticks: assert property (@(posedge clk) disable iff (rst)
    (ticks != $past(ticks)) |-> $past(cmd.finish && item.opcode == vftp_pkg::OP_TICK))
    else $error("tick count moved");
  a_ring: assert property (@(posedge clk) disable iff (rst)
    !nonempty |-> in_ring == '0) else $error("ring members with empty ring");
endmodule
`default_nettype wire

@@ rtl/vruntime_fair_task_picker_top.sv @@
// Top level of the task picker: configuration registers, output register, ctrl and dp.
// Depends on vftp_pkg, vftp_ctrl and vftp_dp.
//
// Input words (opcode, slot, nice_value, new_state) arrive on in_valid/in_stall;
// one result word per input leaves on out_valid/out_stall. The block handles one
// word at a time: in_stall is high from acceptance until its result is loaded.
// Tick, add, set nice and set state pass from acceptance through the decide state
// to the finish step; remove of a multi-member ring member first searches the
// slots for its ring predecessor; switch on a non-empty ring walks the ring one
// member a cycle, then scans the pool one slot a cycle until a ready slot is found
// or the pool limit is reached, unless the walk already found a ready member.
// A result held under out_stall keeps its value; the next word may be accepted
// meanwhile, but its result waits until the output register is free.
// Configuration: cfg_valid/cfg_ready, cfg_index 0 timeslice reload, 1 pool size;
// cfg_ready is always high. Reset (rst, synchronous) empties the ring, makes slot 0
// the idle task, clears the tick count and loads timeslice 10, pool 1.
`default_nettype none
module vruntime_fair_task_picker_top (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire vftp_pkg::in_word_t in_data,
  output logic out_valid,
  input  wire logic out_stall,
  output vftp_pkg::out_word_t out_data,
  input  wire logic cfg_valid,
  output logic cfg_ready,
  input  wire logic [0:0] cfg_index,
  input  wire logic [7:0] cfg_data
);
  logic [7:0] timeslice;
  logic [4:0] pool;
  vftp_pkg::dp_cmd_t cmd;
  vftp_pkg::dp_sts_t sts;
  vftp_pkg::out_word_t res;
  logic busy, out_free, pend;

  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      timeslice <= 8'd10;
      pool <= 5'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        vftp_pkg::REG_TIMESLICE: timeslice <= cfg_data;
        vftp_pkg::REG_POOL: pool <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  assign in_stall = busy;
  assign out_free = !out_valid || !out_stall;

  vftp_ctrl u_ctrl (.clk, .rst, .in_go(in_valid), .sts, .out_free, .cmd, .busy);
  vftp_dp u_dp (.clk, .rst, .in_word(in_data), .cmd, .timeslice, .pool, .sts, .res);

  // The result register of the datapath loads on finish; pend then sets out_valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pend <= cmd.finish;
      if (pend) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
  assign out_data = res;

  a_one: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> (!out_valid || !out_stall)) else $error("result overwritten");
  a_pend: assert property (@(posedge clk) disable iff (rst)
    pend |=> out_valid) else $error("result not shown");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data)) else $error("held result moved");
endmodule
`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the vruntime task picker: a scoreboard class predicts each
// result word, plain tasks drive input and register channels, a process stalls output.
// Depends on vftp_pkg and vruntime_fair_task_picker_top.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SettleCycles = 40;
  localparam int CycleLimit = 900000;

  class picker_scoreboard;
    logic [1:0] state_of[vftp_pkg::Slots];
    logic [31:0] vrun[vftp_pkg::Slots];
    int nice_of[vftp_pkg::Slots];
    logic [7:0] slice[vftp_pkg::Slots];
    logic [31:0] cpu[vftp_pkg::Slots];
    logic [3:0] succ[vftp_pkg::Slots];
    bit member[vftp_pkg::Slots];
    logic [3:0] head;
    bit ring_used;
    logic [3:0] running;
    logic [31:0] ticks;
    logic [7:0] timeslice;
    logic [4:0] pool;
    vftp_pkg::out_word_t pending[$];
    int errors;
    int checked;
    int switches;
    int fallbacks;

    function void clear();
      for (int i = 0; i < vftp_pkg::Slots; i++) begin
        state_of[i] = vftp_pkg::ST_ENDED;
        vrun[i] = '0;
        nice_of[i] = 0;
        slice[i] = '0;
        cpu[i] = '0;
        succ[i] = '0;
        member[i] = 1'b0;
      end
      state_of[0] = vftp_pkg::ST_READY;
      head = '0;
      ring_used = 1'b0;
      running = '0;
      ticks = '0;
      timeslice = 8'd10;
      pool = 5'd1;
    endfunction

    function void write_reg(logic [0:0] idx, logic [7:0] value);
      if (idx == vftp_pkg::REG_TIMESLICE) timeslice = value;
      else pool = value[4:0];
    endfunction

    function logic [3:0] choose(output bit by_pool);
      logic [3:0] best, walker;
      int lim;
      by_pool = 1'b0;
      if (!ring_used) return '0;
      best = head;
      walker = head;
      for (int n = 0; n < vftp_pkg::Slots; n++) begin
        if (state_of[walker] == vftp_pkg::ST_READY &&
            (state_of[best] != vftp_pkg::ST_READY || vrun[walker] < vrun[best]))
          best = walker;
        walker = succ[walker];
        if (walker == head) break;
      end
      if (state_of[best] == vftp_pkg::ST_READY) return best;
      lim = int'(pool) < vftp_pkg::Slots ? int'(pool) : vftp_pkg::Slots;
      for (int i = 0; i < lim; i++)
        if (state_of[i] == vftp_pkg::ST_READY) begin
          by_pool = 1'b1;
          return i[3:0];
        end
      return '0;
    endfunction

    function void note_input(vftp_pkg::in_word_t w);
      vftp_pkg::out_word_t r;
      bit sw, fb;
      logic [3:0] nx, s, p;
      int n, wgt;
      sw = 1'b0;
      fb = 1'b0;
      s = w.slot;
      case (w.opcode)
        vftp_pkg::OP_TICK: begin
          if (running != '0) begin
            cpu[running]++;
            wgt = 1024 - 40 * nice_of[running];
            if (wgt < 1) wgt = 1;
            vrun[running] += 32'(10240 / wgt);
            if (slice[running] != '0) slice[running]--;
          end
          ticks++;
        end
        vftp_pkg::OP_SWITCH: begin
          if (running != '0 && slice[running] == '0) slice[running] = timeslice;
          nx = choose(fb);
          if (nx != running) begin
            running = nx;
            sw = 1'b1;
            if (state_of[nx] == vftp_pkg::ST_READY) state_of[nx] = vftp_pkg::ST_RUNNING;
          end
        end
        vftp_pkg::OP_ADD: begin
          nice_of[s] = 0;
          vrun[s] = ticks;
          slice[s] = timeslice;
          if (!member[s]) begin
            if (!ring_used) begin
              head = s;
              succ[s] = s;
              ring_used = 1'b1;
            end else begin
              succ[s] = succ[head];
              succ[head] = s;
            end
            member[s] = 1'b1;
          end
          state_of[s] = vftp_pkg::ST_READY;
        end
        vftp_pkg::OP_REMOVE: begin
          if (ring_used && member[s]) begin
            if (succ[s] == s) begin
              ring_used = 1'b0;
              head = '0;
            end else begin
              // The predecessor is the first member pointing at the slot.
              p = s;
              for (int j = vftp_pkg::Slots - 1; j >= 0; j--)
                if (member[j] && succ[j] == s) p = j[3:0];
              succ[p] = succ[s];
              if (head == s) head = succ[s];
            end
            succ[s] = '0;
            member[s] = 1'b0;
          end
        end
        vftp_pkg::OP_NICE: begin
          n = int'(w.nice_value);
          if (n < -20) n = -20;
          if (n > 19) n = 19;
          nice_of[s] = n;
        end
        vftp_pkg::OP_STATE: state_of[s] = w.new_state;
        default: ;
      endcase
      switches += sw;
      fallbacks += fb;
      r.current_slot = running;
      r.switched = sw;
      r.used_fallback = fb;
      r.tick_count = ticks;
      pending.push_back(r);
    endfunction

    function void check_result(vftp_pkg::out_word_t got);
      vftp_pkg::out_word_t want;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: result word with nothing expected: %p", $time, got);
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.current_slot !== want.current_slot || got.switched !== want.switched ||
          got.used_fallback !== want.used_fallback || got.tick_count !== want.tick_count) begin
        errors++;
        $display("%0t: mismatch, expected %p, actual %p", $time, want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst;
  logic in_valid;
  logic in_stall;
  vftp_pkg::in_word_t in_data;
  logic out_valid;
  logic out_stall;
  vftp_pkg::out_word_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [0:0] cfg_index;
  logic [7:0] cfg_data;

  picker_scoreboard sb = new();
  bit quiet;
  int stall_left;
  int cycles;
  int sent;

  vruntime_fair_task_picker_top i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("%0t: run timed out", $time);
      $display("[vruntime_fair_task_picker_top] ERROR");
      $finish;
    end
  end

  // Receiver stalls come in bursts; none once the run goes quiet.
  always @(posedge clk) begin
    if (quiet || rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      stall_left <= int'($urandom_range(0, 18));
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && !out_stall) sb.check_result(out_data);

  task automatic send_word(vftp_pkg::in_word_t w);
    in_valid <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    sent++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [7:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, value);
    cfg_valid <= 1'b0;
  endtask

  function automatic vftp_pkg::in_word_t make_word(logic [2:0] op, logic [3:0] s,
                                                   logic [7:0] nv, logic [1:0] st);
    vftp_pkg::in_word_t w;
    w.opcode = op;
    w.slot = s;
    w.nice_value = nv;
    w.new_state = st;
    return w;
  endfunction

  // Mostly a small working set of slots so that the ring stays busy.
  function automatic vftp_pkg::in_word_t random_word();
    int pick;
    logic [2:0] op;
    logic [3:0] s;
    logic [7:0] nv;
    pick = int'($urandom_range(0, 99));
    if (pick < 30) op = vftp_pkg::OP_TICK;
    else if (pick < 55) op = vftp_pkg::OP_SWITCH;
    else if (pick < 70) op = vftp_pkg::OP_ADD;
    else if (pick < 78) op = vftp_pkg::OP_REMOVE;
    else if (pick < 86) op = vftp_pkg::OP_NICE;
    else if (pick < 96) op = vftp_pkg::OP_STATE;
    else op = 3'($urandom_range(6, 7));
    s = $urandom_range(0, 3) == 0 ? 4'($urandom) : 4'($urandom_range(0, 6));
    nv = $urandom_range(0, 1) != 0 ? 8'($urandom) : 8'($urandom_range(0, 50) - 25);
    return make_word(op, s, nv, 2'($urandom));
  endfunction

  task automatic random_phase(int count);
    repeat (count) send_word(random_word());
  endtask

  initial begin
    vftp_pkg::in_word_t directed[$];
    sb.clear();
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= vftp_pkg::REG_TIMESLICE;
    cfg_data <= 8'd0;
    out_stall <= 1'b0;
    quiet = 1'b0;
    cycles = 0;
    sent = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Empty ring, unused opcodes, ticks on idle, table edits at the extremes.
    directed = '{
      make_word(vftp_pkg::OP_SWITCH, 4'd0, 8'd0, 2'd0),
      make_word(3'd6, 4'hf, 8'hff, 2'd3),
      make_word(3'd7, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_TICK, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_REMOVE, 4'd5, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_ADD, 4'hf, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_ADD, 4'd3, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_ADD, 4'd3, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_NICE, 4'hf, 8'h80, 2'd0),
      make_word(vftp_pkg::OP_NICE, 4'd3, 8'h7f, 2'd0),
      make_word(vftp_pkg::OP_SWITCH, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_TICK, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_TICK, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_REMOVE, 4'd3, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_STATE, 4'hf, 8'd0, vftp_pkg::ST_ENDED),
      make_word(vftp_pkg::OP_STATE, 4'd3, 8'd0, vftp_pkg::ST_BLOCKED),
      make_word(vftp_pkg::OP_SWITCH, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_STATE, 4'd0, 8'd0, vftp_pkg::ST_RUNNING),
      make_word(vftp_pkg::OP_STATE, 4'd5, 8'd0, vftp_pkg::ST_READY),
      make_word(vftp_pkg::OP_SWITCH, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_REMOVE, 4'hf, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_SWITCH, 4'd0, 8'd0, 2'd0),
      make_word(vftp_pkg::OP_TICK, 4'd0, 8'd0, 2'd0)
    };
    foreach (directed[i]) send_word(directed[i]);

    write_reg(vftp_pkg::REG_TIMESLICE, 8'd1);
    write_reg(vftp_pkg::REG_POOL, 8'd16);
    random_phase(250);
    write_reg(vftp_pkg::REG_TIMESLICE, 8'd255);
    write_reg(vftp_pkg::REG_POOL, 8'd0);
    random_phase(200);
    write_reg(vftp_pkg::REG_POOL, 8'd31);
    write_reg(vftp_pkg::REG_TIMESLICE, 8'd3);
    random_phase(250);
    write_reg(vftp_pkg::REG_POOL, 8'd1);
    drain();
    quiet = 1'b1;
    random_phase(180);
    drain();

    $display("Sent %0d words, checked %0d results, %0d switches, %0d by pool scan.",
             sent, sb.checked, sb.switches, sb.fallbacks);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[vruntime_fair_task_picker_top] OK");
    end else begin
      $display("[vruntime_fair_task_picker_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
